[src/tsopt_pkg.sv]
package tsopt_pkg;

   // Width of the option byte counters; the option area never exceeds 40 bytes.
   localparam int AREA_W = 6;

   // Option kinds and lengths from the TCP option layout.
   localparam logic [7:0] KIND_END_LIST = 8'd0;
   localparam logic [7:0] KIND_NO_OP    = 8'd1;
   localparam logic [7:0] KIND_TSTAMP   = 8'd8;
   localparam logic [7:0] LEN_TSTAMP    = 8'd10;
   localparam logic [7:0] TCPOLEN_MIN   = 8'd2;

   // Smallest legal data offset, in 32-bit words, and the fixed header size in bytes.
   localparam logic [3:0] HDR_WORDS_MIN = 4'd5;
   localparam logic [AREA_W-1:0] HDR_BYTES = AREA_W'(20);

   // Capture walks four value bytes and then four echo bytes.
   localparam logic [3:0] CAPTURE_SPLIT = 4'd4;
   localparam logic [3:0] CAPTURE_BYTES = 4'd8;
   localparam logic [3:0] OPTIONS_SAT   = 4'd15;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_NOT_FOUND = 2'd0,
      ST_FOUND     = 2'd1,
      ST_MALFORMED = 2'd2
   } status_type;

   // Walk position inside the option area.
   typedef enum logic [4:0] {
      PH_KIND      = 5'b00001,
      PH_LEN_OTHER = 5'b00010,
      PH_LEN_TS    = 5'b00100,
      PH_CAPTURE   = 5'b01000,
      PH_SKIP      = 5'b10000
   } phase_type;

   // One accepted input beat as held in the input register.
   typedef struct packed {
      logic [7:0] option_byte;
      logic       byte_valid;
      logic       first_item;
      logic       last_item;
      logic [3:0] header_words;
   } req_beat_type;

   // Result of the parser for the beat being processed.
   typedef struct packed {
      status_type  parse_status;
      logic [31:0] ts_value;
      logic [31:0] ts_echo;
   } rsp_beat_type;

endpackage

[src/tsopt_ifs.sv]
// Input channel: one option-area byte per beat.
interface tsopt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] option_byte;
   logic       byte_valid;
   logic       first_item;
   logic       last_item;
   logic [3:0] header_words;

   modport source (
      output valid, option_byte, byte_valid, first_item, last_item, header_words,
      input  ready
   );
   modport sink (
      input  valid, option_byte, byte_valid, first_item, last_item, header_words,
      output ready
   );
endinterface

// Result channel: one verdict per packet.
interface tsopt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  parse_status;
   logic [31:0] ts_value;
   logic [31:0] ts_echo;

   modport source (
      output valid, parse_status, ts_value, ts_echo,
      input  ready
   );
   modport sink (
      input  valid, parse_status, ts_value, ts_echo,
      output ready
   );
endinterface

// Configuration write channel for the max_options register.
interface tsopt_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] wdata;

   modport source (
      output valid, wdata,
      input  ready
   );
   modport sink (
      input  valid, wdata,
      output ready
   );
endinterface

[src/tsopt_parser.sv]
module tsopt_parser
   import tsopt_pkg::*;
#(
   parameter int OPTION_AREA_MAX = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_beat_type beat,
   input  logic [3:0]   max_options,
   output rsp_beat_type result
);

   localparam logic [AREA_W-1:0] AREA_CAP = AREA_W'(OPTION_AREA_MAX);

   phase_type         phase_ff, phase_in;
   logic [AREA_W-1:0] bytes_left_ff, bytes_left_in;
   logic [3:0]        options_seen_ff, options_seen_in;
   logic [AREA_W-1:0] skip_count_ff, skip_count_in;
   logic [3:0]        capture_index_ff, capture_index_in;
   logic [31:0]       ts_shift_ff, ts_shift_in;
   logic [31:0]       echo_shift_ff, echo_shift_in;
   status_type        verdict_ff, verdict_in;
   logic              verdict_fixed_ff, verdict_fixed_in;
   logic [AREA_W-1:0] area;
   logic [7:0]        b;

   assign b = beat.option_byte;

   // Option byte count from the data offset, clamped to the area limit.
   always_comb begin
      area = {beat.header_words, 2'b00} - HDR_BYTES;
      if (area > AREA_CAP) begin
         area = AREA_CAP;
      end
   end

   // Packet start, then one step of the option walk, then the end-of-packet check.
   always_comb begin
      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      options_seen_in  = options_seen_ff;
      skip_count_in    = skip_count_ff;
      capture_index_in = capture_index_ff;
      ts_shift_in      = ts_shift_ff;
      echo_shift_in    = echo_shift_ff;
      verdict_in       = verdict_ff;
      verdict_fixed_in = verdict_fixed_ff;

      if (step && beat.first_item) begin
         phase_in         = PH_KIND;
         bytes_left_in    = '0;
         options_seen_in  = '0;
         skip_count_in    = '0;
         capture_index_in = '0;
         ts_shift_in      = '0;
         echo_shift_in    = '0;
         verdict_in       = ST_NOT_FOUND;
         verdict_fixed_in = 1'b0;
         if (beat.header_words < HDR_WORDS_MIN) begin
            verdict_in       = ST_MALFORMED;
            verdict_fixed_in = 1'b1;
         end else begin
            bytes_left_in = area;
            if (max_options == '0) begin
               verdict_in       = ST_NOT_FOUND;
               verdict_fixed_in = 1'b1;
            end
         end
      end

      if (step && beat.byte_valid && !verdict_fixed_in) begin
         case (phase_in)
            PH_KIND: begin
               if (bytes_left_in == '0 || b == KIND_END_LIST) begin
                  verdict_in       = ST_MALFORMED;
                  verdict_fixed_in = 1'b1;
               end else if (b == KIND_NO_OP) begin
                  bytes_left_in = bytes_left_in - AREA_W'(1);
                  if (options_seen_in != OPTIONS_SAT) begin
                     options_seen_in = options_seen_in + 4'd1;
                  end
                  if (options_seen_in >= max_options) begin
                     verdict_in       = ST_NOT_FOUND;
                     verdict_fixed_in = 1'b1;
                  end
               end else begin
                  phase_in = (b == KIND_TSTAMP) ? PH_LEN_TS : PH_LEN_OTHER;
               end
            end
            PH_LEN_OTHER, PH_LEN_TS: begin
               if (b < TCPOLEN_MIN || b > {{(8 - AREA_W){1'b0}}, bytes_left_in}) begin
                  verdict_in       = ST_MALFORMED;
                  verdict_fixed_in = 1'b1;
               end else begin
                  bytes_left_in = bytes_left_in - b[AREA_W-1:0];
                  if (options_seen_in != OPTIONS_SAT) begin
                     options_seen_in = options_seen_in + 4'd1;
                  end
                  if (phase_in == PH_LEN_TS) begin
                     if (b == LEN_TSTAMP) begin
                        phase_in         = PH_CAPTURE;
                        capture_index_in = '0;
                     end else begin
                        verdict_in       = ST_FOUND;
                        verdict_fixed_in = 1'b1;
                     end
                  end else if (options_seen_in >= max_options) begin
                     verdict_in       = ST_NOT_FOUND;
                     verdict_fixed_in = 1'b1;
                  end else begin
                     skip_count_in = b[AREA_W-1:0] - AREA_W'(2);
                     phase_in      = (skip_count_in != '0) ? PH_SKIP : PH_KIND;
                  end
               end
            end
            PH_CAPTURE: begin
               if (capture_index_in < CAPTURE_SPLIT) begin
                  ts_shift_in = {ts_shift_in[23:0], b};
               end else begin
                  echo_shift_in = {echo_shift_in[23:0], b};
               end
               capture_index_in = capture_index_in + 4'd1;
               if (capture_index_in >= CAPTURE_BYTES) begin
                  verdict_in       = ST_FOUND;
                  verdict_fixed_in = 1'b1;
               end
            end
            PH_SKIP: begin
               if (skip_count_in != '0) begin
                  skip_count_in = skip_count_in - AREA_W'(1);
               end
               if (skip_count_in == '0) begin
                  phase_in = PH_KIND;
               end
            end
            default: begin
               verdict_in       = ST_MALFORMED;
               verdict_fixed_in = 1'b1;
            end
         endcase
      end

      // A packet that ends before a verdict is malformed.
      if (step && beat.last_item && !verdict_fixed_in) begin
         verdict_in       = ST_MALFORMED;
         verdict_fixed_in = 1'b1;
      end
   end

   // Result of this beat; captured fields show only with a found verdict.
   always_comb begin
      result.parse_status = verdict_in;
      if (verdict_in == ST_FOUND) begin
         result.ts_value = ts_shift_in;
         result.ts_echo  = echo_shift_in;
      end else begin
         result.ts_value = '0;
         result.ts_echo  = '0;
      end
   end

   // Walk state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_KIND;
         bytes_left_ff    <= '0;
         options_seen_ff  <= '0;
         skip_count_ff    <= '0;
         capture_index_ff <= '0;
         ts_shift_ff      <= '0;
         echo_shift_ff    <= '0;
         verdict_ff       <= ST_NOT_FOUND;
         verdict_fixed_ff <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         options_seen_ff  <= options_seen_in;
         skip_count_ff    <= skip_count_in;
         capture_index_ff <= capture_index_in;
         ts_shift_ff      <= ts_shift_in;
         echo_shift_ff    <= echo_shift_in;
         verdict_ff       <= verdict_in;
         verdict_fixed_ff <= verdict_fixed_in;
      end
   end

endmodule

[src/tcp_timestamp_option_parser_top.sv]
// Channel   Modport  Direction  Beat contents
// req_bus   sink     in         option_byte, byte_valid, first_item, last_item, header_words
// rsp_bus   source   out        parse_status, ts_value, ts_echo (one beat per packet)
// csr_bus   sink     in         wdata: max_options, always ready
//
// One option byte is taken every cycle unless the input register stalls; a beat
// waits in the input register, and on the last beat of a packet its result is
// written into the output register as the beat moves on. The walk state updates
// once per beat in the parser. The input register only stalls when a last beat
// meets an output register that is full and not being drained. Reset is synchronous
// and sets max_options to 4 and the walk to its idle state.
module tcp_timestamp_option_parser_top
   import tsopt_pkg::*;
#(
   parameter int OPTION_AREA_MAX = 40
) (
   input  logic               clock,
   input  logic               reset,
   tsopt_req_if.sink          req_bus,
   tsopt_rsp_if.source        rsp_bus,
   tsopt_csr_if.sink          csr_bus
);

   localparam logic [3:0] MAX_OPTIONS_RESET = 4'd4;

   logic         in_valid_ff, in_valid_in;
   req_beat_type in_beat_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff;
   logic [3:0]   max_options_ff;
   logic         req_take;
   logic         rsp_free;
   logic         step;
   rsp_beat_type result;

   // Handshake: the held beat moves on unless its result has nowhere to go.
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && (!in_beat_ff.last_item || rsp_free);
   assign req_bus.ready = !in_valid_ff || step;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step && in_beat_ff.last_item) ? 1'b1 :
                         (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_options_ff <= MAX_OPTIONS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            max_options_ff <= csr_bus.wdata;
         end
      end
   end

   // Input beat register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff.option_byte  <= req_bus.option_byte;
         in_beat_ff.byte_valid   <= req_bus.byte_valid;
         in_beat_ff.first_item   <= req_bus.first_item;
         in_beat_ff.last_item    <= req_bus.last_item;
         in_beat_ff.header_words <= req_bus.header_words;
      end
   end

   // Option walk.
   tsopt_parser #(
      .OPTION_AREA_MAX (OPTION_AREA_MAX)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .beat        (in_beat_ff),
      .max_options (max_options_ff),
      .result      (result)
   );

   // Output beat register.
   always_ff @(posedge clock) begin
      if (step && in_beat_ff.last_item) begin
         rsp_beat_ff <= result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.parse_status = rsp_beat_ff.parse_status;
   assign rsp_bus.ts_value     = rsp_beat_ff.ts_value;
   assign rsp_bus.ts_echo      = rsp_beat_ff.ts_echo;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
   import tsopt_pkg::*;
();

   // Largest option area a data offset can describe, in bytes.
   localparam int AREA_MAX_BYTES = 40;

   // Tracks the option walk of the parser and holds the verdicts still owed by it.
   class timestamp_scoreboard;
      logic [3:0]        max_options;
      phase_type         phase;
      logic [AREA_W-1:0] bytes_left;
      logic [3:0]        options_seen;
      logic [AREA_W-1:0] skip_left;
      logic [3:0]        capture_idx;
      logic [31:0]       value_sr;
      logic [31:0]       echo_sr;
      status_type        verdict;
      bit                decided;
      rsp_beat_type      verdicts_due[$];
      int                errors;

      function new();
         max_options = 4'd4;
         errors = 0;
         restart();
      endfunction

      // Forget everything about the current packet.
      function void restart();
         phase = PH_KIND;
         bytes_left = '0;
         options_seen = '0;
         skip_left = '0;
         capture_idx = '0;
         value_sr = '0;
         echo_sr = '0;
         verdict = ST_NOT_FOUND;
         decided = 1'b0;
      endfunction

      function void settle(status_type s);
         verdict = s;
         decided = 1'b1;
      endfunction

      function void count_option();
         if (options_seen < OPTIONS_SAT) options_seen++;
      endfunction

      // Advance the walk by one option byte.
      function void walk_byte(logic [7:0] b);
         case (phase)
            PH_KIND: begin
               if (bytes_left == 0 || b == KIND_END_LIST) begin
                  settle(ST_MALFORMED);
               end else if (b == KIND_NO_OP) begin
                  bytes_left--;
                  count_option();
                  if (options_seen >= max_options) settle(ST_NOT_FOUND);
               end else if (b == KIND_TSTAMP) begin
                  phase = PH_LEN_TS;
               end else begin
                  phase = PH_LEN_OTHER;
               end
            end
            PH_LEN_OTHER, PH_LEN_TS: begin
               if (b < TCPOLEN_MIN || b > bytes_left) begin
                  settle(ST_MALFORMED);
               end else begin
                  bytes_left = bytes_left - b[AREA_W-1:0];
                  count_option();
                  if (phase == PH_LEN_TS) begin
                     if (b == LEN_TSTAMP) begin
                        phase = PH_CAPTURE;
                        capture_idx = '0;
                     end else begin
                        settle(ST_FOUND);
                     end
                  end else if (options_seen >= max_options) begin
                     settle(ST_NOT_FOUND);
                  end else begin
                     skip_left = b[AREA_W-1:0] - AREA_W'(2);
                     if (skip_left != 0) phase = PH_SKIP;
                     else phase = PH_KIND;
                  end
               end
            end
            PH_CAPTURE: begin
               // Four value bytes come first, then four echo bytes, most significant first.
               if (capture_idx < CAPTURE_SPLIT) value_sr = {value_sr[23:0], b};
               else echo_sr = {echo_sr[23:0], b};
               capture_idx++;
               if (capture_idx >= CAPTURE_BYTES) settle(ST_FOUND);
            end
            PH_SKIP: begin
               if (skip_left > 0) skip_left--;
               if (skip_left == 0) phase = PH_KIND;
            end
            default: settle(ST_MALFORMED);
         endcase
      endfunction

      // Apply one accepted input beat; a last beat owes a verdict.
      function void note_beat(req_beat_type t);
         rsp_beat_type r;
         int area;
         if (t.first_item) begin
            restart();
            if (t.header_words < HDR_WORDS_MIN) begin
               settle(ST_MALFORMED);
            end else begin
               area = int'(t.header_words) * 4 - int'(HDR_BYTES);
               if (area > AREA_MAX_BYTES) area = AREA_MAX_BYTES;
               bytes_left = AREA_W'(area);
               if (max_options == 0) settle(ST_NOT_FOUND);
            end
         end
         if (t.byte_valid && !decided) walk_byte(t.option_byte);
         if (t.last_item) begin
            if (!decided) settle(ST_MALFORMED);
            r.parse_status = verdict;
            r.ts_value = (verdict == ST_FOUND) ? value_sr : '0;
            r.ts_echo = (verdict == ST_FOUND) ? echo_sr : '0;
            verdicts_due.push_back(r);
         end
      endfunction

      // Compare one accepted result beat with the oldest verdict owed.
      function void check_verdict(logic [1:0] status, logic [31:0] value, logic [31:0] echo);
         rsp_beat_type want;
         if (verdicts_due.size() == 0) begin
            $error("result beat with no verdict owed: parse_status %0d", status);
            errors++;
         end else begin
            want = verdicts_due.pop_front();
            if (status !== want.parse_status) begin
               $error("parse_status: expected %0d, got %0d", want.parse_status, status);
               errors++;
            end
            if (value !== want.ts_value) begin
               $error("ts_value: expected %08h, got %08h", want.ts_value, value);
               errors++;
            end
            if (echo !== want.ts_echo) begin
               $error("ts_echo: expected %08h, got %08h", want.ts_echo, echo);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tsopt_req_if req_bus ();
   tsopt_rsp_if rsp_bus ();
   tsopt_csr_if csr_bus ();

   tcp_timestamp_option_parser_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   timestamp_scoreboard board = new();
   int beats_sent = 0;
   bit req_burst = 1'b0;

   // 20 ns clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic req_beat_type pack_beat(input logic [7:0] b, input logic v, input logic f,
                                              input logic l, input logic [3:0] w);
      req_beat_type t;
      t.option_byte = b;
      t.byte_valid = v;
      t.first_item = f;
      t.last_item = l;
      t.header_words = w;
      return t;
   endfunction

   // Offer one beat after a random gap and hold it until the parser takes it.
   task automatic send_beat(input req_beat_type t);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.option_byte <= t.option_byte;
      req_bus.byte_valid <= t.byte_valid;
      req_bus.first_item <= t.first_item;
      req_bus.last_item <= t.last_item;
      req_bus.header_words <= t.header_words;
      do @(posedge clock); while (!req_bus.ready);
      board.note_beat(t);
      beats_sent++;
   endtask

   // Send one packet; outside directed use, empty beats may lead, trail or be mixed in.
   task automatic send_packet(input logic [3:0] words, input logic [7:0] opts[$], input bit plain);
      int n;
      bit lead;
      bit trail;
      bit head;
      n = opts.size();
      lead = !plain && ($urandom_range(0, 9) == 0);
      trail = !plain && ($urandom_range(0, 9) == 0);
      req_burst = !plain && ($urandom_range(0, 3) == 0);
      if (n == 0) begin
         send_beat(pack_beat(8'($urandom), 1'b0, 1'b1, 1'b1, words));
      end else begin
         if (lead) send_beat(pack_beat(8'($urandom), 1'b0, 1'b1, 1'b0, words));
         for (int i = 0; i < n; i++) begin
            head = (i == 0) && !lead;
            send_beat(pack_beat(opts[i], 1'b1, head, (i == n - 1) && !trail,
                                head ? words : 4'($urandom)));
            if (!plain && i < n - 1 && $urandom_range(0, 19) == 0)
               send_beat(pack_beat(8'($urandom), 1'b0, 1'b0, 1'b0, 4'($urandom)));
         end
         if (trail) send_beat(pack_beat(8'($urandom), 1'b0, 1'b0, 1'b1, 4'($urandom)));
      end
   endtask

   // Fill an option area of the given size with a mix of options, end-of-list bytes among them.
   task automatic build_options(input int area, output logic [7:0] opts[$]);
      int left;
      int len;
      int pick;
      logic [7:0] kind;
      opts.delete();
      left = area;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 25 || left < 2) begin
            opts.push_back(KIND_NO_OP);
            left--;
         end else if (pick < 45 && left >= 10) begin
            opts.push_back(KIND_TSTAMP);
            opts.push_back(LEN_TSTAMP);
            repeat (8) opts.push_back(8'($urandom));
            left -= 10;
         end else if (pick < 52) begin
            len = $urandom_range(2, (left < 10) ? left : 10);
            opts.push_back(KIND_TSTAMP);
            opts.push_back(8'(len));
            repeat (len - 2) opts.push_back(8'($urandom));
            left -= len;
         end else if (pick < 55) begin
            opts.push_back(KIND_END_LIST);
            left--;
         end else begin
            kind = 8'($urandom_range(2, 255));
            if (kind == KIND_TSTAMP) kind = 8'd9;
            len = $urandom_range(2, (left < 12) ? left : 12);
            opts.push_back(kind);
            opts.push_back(8'(len));
            repeat (len - 2) opts.push_back(8'($urandom));
            left -= len;
         end
      end
   endtask

   // Mostly legal packets, some damaged ones and some plain noise.
   task automatic random_packet();
      logic [7:0] opts[$];
      logic [7:0] odd_bytes[4] = '{8'h00, 8'h01, 8'h02, 8'hFF};
      logic [3:0] words;
      int style;
      int area;
      int pos;
      style = $urandom_range(0, 99);
      if (style < 92) begin
         if ($urandom_range(0, 2) != 0) words = 4'($urandom_range(5, 9));
         else words = 4'($urandom_range(10, 15));
      end else begin
         words = 4'($urandom_range(0, 4));
      end
      area = (words >= HDR_WORDS_MIN) ? int'(words) * 4 - 20 : $urandom_range(0, 6);
      build_options(area, opts);
      if (style >= 88) begin
         opts.delete();
         repeat ($urandom_range(0, 12)) opts.push_back(8'($urandom));
      end else if (style >= 70 && opts.size() > 0) begin
         pos = $urandom_range(0, opts.size() - 1);
         case ($urandom_range(0, 3))
            0: while (opts.size() > pos) void'(opts.pop_back());
            1: opts[pos] = odd_bytes[$urandom_range(0, 3)];
            2: repeat ($urandom_range(1, 6)) opts.push_back(8'($urandom));
            default: opts[pos] = 8'($urandom);
         endcase
      end
      send_packet(words, opts, 1'b0);
      // Now and then a stray beat outside any packet.
      if ($urandom_range(0, 29) == 0)
         send_beat(pack_beat(8'($urandom), 1'($urandom), 1'b0, 1'($urandom), 4'($urandom)));
   endtask

   // Stop offering and wait until every owed verdict has come back.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_options(input logic [3:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.wdata <= v;
      do @(posedge clock); while (!csr_bus.ready);
      board.max_options = v;
      csr_bus.valid <= 1'b0;
   endtask

   // Result side: a random stall before each beat, quiet stretches and two long hold-offs.
   initial begin : result_sink
      int stall_left;
      int taken;
      stall_left = 0;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            board.check_verdict(rsp_bus.parse_status, rsp_bus.ts_value, rsp_bus.ts_echo);
            taken++;
            stall_left = ((taken / 16) % 3 == 0) ? 0 : $urandom_range(0, 9);
            if (taken == 15 || taken == 100) stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed packets, then random phases under several settings.
   initial begin : stimulus
      logic [3:0] setting;
      int target;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.option_byte <= '0;
      req_bus.byte_valid <= 1'b0;
      req_bus.first_item <= 1'b0;
      req_bus.last_item <= 1'b0;
      req_bus.header_words <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A byte before any packet start, then a repeated last beat.
      send_beat(pack_beat(8'h08, 1'b1, 1'b0, 1'b1, 4'hF));
      send_beat(pack_beat(8'h00, 1'b0, 1'b0, 1'b1, 4'h0));
      // Short header and an option byte with an empty area.
      send_packet(4'd4, '{8'hFF}, 1'b1);
      send_packet(4'd5, '{KIND_NO_OP}, 1'b1);
      // Full timestamp with extreme bytes; the trailing bytes come after the verdict.
      send_packet(4'd8, '{KIND_TSTAMP, LEN_TSTAMP, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          8'h00, 8'h00, 8'h00, 8'h00, KIND_END_LIST, KIND_NO_OP}, 1'b1);
      // End of list, a short timestamp, a length past the area and a length below two.
      send_packet(4'd6, '{KIND_END_LIST}, 1'b1);
      send_packet(4'd6, '{KIND_TSTAMP, 8'd4, 8'h12, 8'h34}, 1'b1);
      send_packet(4'd6, '{8'd3, 8'd5}, 1'b1);
      send_packet(4'd6, '{8'd3, 8'd1}, 1'b1);

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: setting = 4'd15;
            1: setting = 4'd1;
            2: setting = 4'd0;
            3: setting = 4'($urandom_range(2, 14));
            4: setting = 4'd15;
            5: setting = 4'($urandom);
            default: setting = 4'd4;
         endcase
         wait_idle();
         write_max_options(setting);
         target = beats_sent + ((setting == 0) ? 80 : 290);
         while (beats_sent < target) random_packet();
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.verdicts_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin : watchdog
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
src/tsopt_pkg.sv
src/tsopt_ifs.sv
src/tsopt_parser.sv
src/tcp_timestamp_option_parser_top.sv
sim/tb_top.sv
